[rtl/vhpd_pkg.sv]
// ----------------------------------------------------------------------------
// vhpd_pkg
// Types and constants shared by the voxel point deduplication block.
// ----------------------------------------------------------------------------
package vhpd_pkg;

  localparam int TableEntries = 4096;
  localparam int MaxProbes = 16;
  localparam int SlotW = $clog2(TableEntries);
  localparam int Probes = (MaxProbes < TableEntries) ? MaxProbes : TableEntries;
  localparam int ProbeW = $clog2(Probes + 1);
  localparam int KeyW = 35;
  localparam int CountW = 13;
  localparam logic [31:0] InvResReset = 32'd1310720;
  localparam logic [KeyW-1:0] KeyMulZ = KeyW'(345637);
  localparam logic [KeyW-1:0] KeyMulY = KeyW'(1447);
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic               start_of_cloud;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        [23:0] point_color;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] kept_x;
    logic signed [31:0] kept_y;
    logic signed [31:0] kept_z;
    logic        [23:0] kept_color;
    logic               table_overflow;
  } out_item_t;

  typedef struct packed {
    logic               start_of_cloud;
    logic [KeyW-1:0]    key;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        [23:0] point_color;
  } keyed_item_t;

endpackage

[rtl/vhpd_front.sv]
// ----------------------------------------------------------------------------
// vhpd_front
// Scales coordinates to voxel indices and forms the hash key, in three stages.
// ----------------------------------------------------------------------------
module vhpd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           inverse_resolution,
  input  vhpd_pkg::in_item_t    in_item,
  input  logic                  in_valid,
  output logic                  in_ready,
  output vhpd_pkg::keyed_item_t out_item,
  output logic                  out_valid,
  input  logic                  out_ready
);

  logic                  s1_valid;
  vhpd_pkg::in_item_t    s1_item;
  logic [2:0]            s1_neg;
  logic [2:0][31:0]      s1_hi;
  logic                  s2_valid;
  vhpd_pkg::in_item_t    s2_item;
  logic [2:0][15:0]      s2_idx;
  logic                  s3_valid;
  vhpd_pkg::keyed_item_t s3_item;
  logic                  adv1;
  logic                  adv2;
  logic                  adv3;
  logic [2:0][31:0]      mag;
  logic [2:0][63:0]      prod;
  logic [2:0][15:0]      idx;
  logic [vhpd_pkg::KeyW-1:0] key_next;

  assign adv3 = !s3_valid || out_ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;
  assign out_valid = s3_valid;
  assign out_item = s3_item;

  always_comb begin
    mag[0] = in_item.point_x[31] ? 32'(-in_item.point_x) : 32'(in_item.point_x);
    mag[1] = in_item.point_y[31] ? 32'(-in_item.point_y) : 32'(in_item.point_y);
    mag[2] = in_item.point_z[31] ? 32'(-in_item.point_z) : 32'(in_item.point_z);
    for (int i = 0; i < 3; i++) begin
      prod[i] = 64'(mag[i]) * 64'(inverse_resolution);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s1_neg[i]) begin
        idx[i] = (s1_hi[i] > 32'd32768) ? 16'd0 : 16'(32'd32768 - s1_hi[i]);
      end else begin
        idx[i] = (s1_hi[i] > 32'd32767) ? 16'hFFFF : 16'(32'd32768 + s1_hi[i]);
      end
    end
    key_next = vhpd_pkg::KeyW'(s2_idx[2]) * vhpd_pkg::KeyMulZ
             + vhpd_pkg::KeyW'(s2_idx[1]) * vhpd_pkg::KeyMulY
             + vhpd_pkg::KeyW'(s2_idx[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
    end
    if (adv1) begin
      s1_item <= in_item;
      s1_neg <= {in_item.point_z[31], in_item.point_y[31], in_item.point_x[31]};
      for (int i = 0; i < 3; i++) begin
        s1_hi[i] <= prod[i][63:32];
      end
    end
    if (adv2) begin
      s2_item <= s1_item;
      s2_idx <= idx;
    end
    if (adv3) begin
      s3_item.start_of_cloud <= s2_item.start_of_cloud;
      s3_item.key <= key_next;
      s3_item.point_x <= s2_item.point_x;
      s3_item.point_y <= s2_item.point_y;
      s3_item.point_z <= s2_item.point_z;
      s3_item.point_color <= s2_item.point_color;
    end
  end

endmodule

[rtl/vhpd_queue.sv]
// ----------------------------------------------------------------------------
// vhpd_queue
// Short queue of keyed items between the front and back parts.
// ----------------------------------------------------------------------------
module vhpd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  vhpd_pkg::keyed_item_t wr_item,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  output vhpd_pkg::keyed_item_t rd_item,
  output logic                  rd_valid,
  input  logic                  rd_ready
);

  localparam int PtrW = $clog2(vhpd_pkg::QueueDepth);

  vhpd_pkg::keyed_item_t entries [vhpd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (fill != (PtrW+1)'(vhpd_pkg::QueueDepth));
  assign rd_valid = (fill != '0);
  assign rd_item = entries[rd_ptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

[rtl/vhpd_back.sv]
// ----------------------------------------------------------------------------
// vhpd_back
// Hash set probe sequencer over a single-port key memory, with epoch-marked
// slots so that a new cloud clears the set at once.
// ----------------------------------------------------------------------------
module vhpd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  vhpd_pkg::keyed_item_t in_item,
  input  logic                  in_valid,
  output logic                  in_ready,
  output vhpd_pkg::out_item_t   out_item,
  output logic                  out_valid,
  input  logic                  out_ready
);

  localparam int SlotW = vhpd_pkg::SlotW;
  localparam int EpochW = 4;
  localparam int EntryW = vhpd_pkg::KeyW + EpochW + 1;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCheck = 2'd2;

  // Each entry holds a valid mark, an epoch and the key. When the epoch wraps,
  // the memory is swept again so that no entry of an old cloud matches.
  logic [EntryW-1:0] mem [vhpd_pkg::TableEntries];
  logic [EntryW-1:0] rd_data;
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [EpochW-1:0] epoch;
  logic              cleared;
  logic [SlotW-1:0]  clr_addr;
  vhpd_pkg::keyed_item_t cur;
  logic [SlotW-1:0]  slot;
  logic [vhpd_pkg::ProbeW-1:0] probes;
  logic [vhpd_pkg::CountW-1:0] stored_count;
  logic              hit_valid;
  logic              last_probe;
  logic              emit;

  assign in_ready = cleared && (state == StIdle) && (!out_valid || out_ready);
  assign hit_valid = rd_data[EntryW-1] && (rd_data[EntryW-2:vhpd_pkg::KeyW] == epoch);
  assign last_probe = (probes == vhpd_pkg::ProbeW'(vhpd_pkg::Probes - 1));
  assign emit = (state == StCheck) && (!hit_valid || last_probe)
                && !(hit_valid && rd_data[vhpd_pkg::KeyW-1:0] == cur.key);

  always_comb begin
    state_next = state;
    unique case (state)
      StIdle: begin
        if (in_valid && in_ready) begin
          state_next = StRead;
        end
      end
      StRead: begin
        if (cleared) begin
          state_next = StCheck;
        end
      end
      StCheck: begin
        if (!hit_valid || rd_data[vhpd_pkg::KeyW-1:0] == cur.key || last_probe) begin
          state_next = StIdle;
        end else begin
          state_next = StRead;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == StRead && cleared) begin
      rd_data <= mem[slot];
    end
    if (!cleared) begin
      mem[clr_addr] <= '0;
    end else if (state == StCheck && !hit_valid) begin
      mem[slot] <= {1'b1, epoch, cur.key};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      epoch <= '0;
      cleared <= 1'b0;
      clr_addr <= '0;
      out_valid <= 1'b0;
      stored_count <= '0;
    end else begin
      state <= state_next;
      if (!cleared) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == SlotW'(vhpd_pkg::TableEntries - 1)) begin
          cleared <= 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == StIdle && in_valid && in_ready && in_item.start_of_cloud) begin
        epoch <= epoch + 1'b1;
        stored_count <= '0;
        if (epoch == '1) begin
          cleared <= 1'b0;
        end
      end
      if (state == StCheck && !hit_valid &&
          stored_count != vhpd_pkg::CountW'(vhpd_pkg::TableEntries)) begin
        stored_count <= stored_count + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
    end
    if (state == StIdle && in_valid && in_ready) begin
      cur <= in_item;
      slot <= in_item.key[SlotW-1:0];
      probes <= '0;
    end else if (state == StCheck) begin
      slot <= slot + 1'b1;
      probes <= probes + 1'b1;
    end
    if (emit) begin
      out_item.kept_x <= cur.point_x;
      out_item.kept_y <= cur.point_y;
      out_item.kept_z <= cur.point_z;
      out_item.kept_color <= cur.point_color;
      out_item.table_overflow <= hit_valid;
    end
  end

endmodule

[rtl/voxel_hash_point_dedup.sv]
// ----------------------------------------------------------------------------
// voxel_hash_point_dedup
// Keeps the first point seen in each voxel of a cloud, using a hash set.
// ----------------------------------------------------------------------------
// A point passes through the front pipeline stages (scale, saturate, key)
// and the queue, and then the back part probes the single-port key
// memory, one slot after another, until a hit, an empty slot or the last
// of up to sixteen probed slots. After reset the key memory is swept, and
// the back part takes no point from the queue until the sweep is done. A
// point flagged as start of cloud clears the set at once by advancing the
// slot epoch; at every sixteenth such point the epoch wraps and the memory
// is swept again before that point is probed.
module voxel_hash_point_dedup (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         cfg_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  vhpd_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  output vhpd_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_ready
);

  logic [31:0]           inverse_resolution;
  vhpd_pkg::keyed_item_t f_item;
  logic                  f_valid;
  logic                  f_ready;
  vhpd_pkg::keyed_item_t q_item;
  logic                  q_valid;
  logic                  q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_resolution <= vhpd_pkg::InvResReset;
    end else if (cfg_valid) begin
      inverse_resolution <= cfg_data;
    end
  end

  vhpd_front u_front (
    .clk, .rst, .inverse_resolution,
    .in_item(in_data), .in_valid, .in_ready,
    .out_item(f_item), .out_valid(f_valid), .out_ready(f_ready)
  );

  vhpd_queue u_queue (
    .clk, .rst,
    .wr_item(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  vhpd_back u_back (
    .clk, .rst,
    .in_item(q_item), .in_valid(q_valid), .in_ready(q_ready),
    .out_item(out_data), .out_valid, .out_ready
  );

endmodule
